/* rtl/cfq_pkg.sv */
// Shared types and constants for the circular FIFO queue.
`default_nettype none

package cfq_pkg;

	localparam int WORD_W = 32;

	localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

	typedef enum logic [1:0] {
		OP_ENQ       = 2'd0,
		OP_DEQ       = 2'd1,
		OP_PEEK_OLD  = 2'd2,
		OP_PEEK_NEW  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic enq;
		logic deq;
	} cfq_ctl_t;

endpackage

`default_nettype wire

/* rtl/circular_fifo_queue.sv */
// Top level of the circular FIFO queue built as a chain of storage cells.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless out_ready stalls; all cells update together.
// The output register frees in the cycle its result is taken, so input and output overlap.
// Reset clears every cell's occupied bit and the output valid; stored words are not cleared.
`default_nettype none

module circular_fifo_queue #(
	parameter int DEPTH = 128
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [1:0]                         func,
	input  wire logic signed [cfq_pkg::WORD_W-1:0]  value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [cfq_pkg::WORD_W-1:0]       data,
	output logic [1:0]                              status,
	output logic                                    is_empty,
	output logic                                    is_full
);
	import cfq_pkg::*;

	logic                     cell_valid [DEPTH];
	logic signed [WORD_W-1:0] cell_data  [DEPTH];
	cfq_ctl_t                 ctl;

	logic                     accept;
	logic                     do_enq;
	logic                     do_deq;
	logic                     empty_now;
	logic                     full_now;
	logic signed [WORD_W-1:0] r_data;
	status_t                  r_status;
	logic                     r_empty;
	logic                     r_full;

	logic signed [WORD_W-1:0] newest_q;
	logic                     out_valid_q;
	logic signed [WORD_W-1:0] data_q;
	status_t                  status_q;
	logic                     is_empty_q;
	logic                     is_full_q;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                     prev_v;
			logic                     next_v;
			logic signed [WORD_W-1:0] next_d;

			if (i == 0) begin : g_first
				assign prev_v = 1'b1;
			end else begin : g_mid
				assign prev_v = cell_valid[i-1];
			end

			if (i == DEPTH - 1) begin : g_last
				assign next_v = 1'b0;
				assign next_d = '0;
			end else begin : g_inner
				assign next_v = cell_valid[i+1];
				assign next_d = cell_data[i+1];
			end

			cfq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.value      (value),
				.prev_valid (prev_v),
				.next_valid (next_v),
				.next_data  (next_d),
				.valid      (cell_valid[i]),
				.data       (cell_data[i])
			);
		end
	endgenerate

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign empty_now = !cell_valid[0];
	assign full_now  = cell_valid[DEPTH-1];

	always_comb begin
		do_enq   = 1'b0;
		do_deq   = 1'b0;
		r_data   = '0;
		r_status = ST_OK;
		r_empty  = empty_now;
		r_full   = full_now;
		case (func)
			OP_ENQ: begin
				if (full_now) begin
					r_status = ST_FULL;
				end else begin
					do_enq  = 1'b1;
					r_empty = 1'b0;
					r_full  = cell_valid[DEPTH-2];
				end
			end
			OP_DEQ: begin
				if (empty_now) begin
					r_data   = EMPTY_WORD;
					r_status = ST_EMPTY;
				end else begin
					do_deq  = 1'b1;
					r_data  = cell_data[0];
					r_full  = 1'b0;
					r_empty = !cell_valid[1];
				end
			end
			OP_PEEK_OLD: begin
				if (empty_now) begin
					r_data   = EMPTY_WORD;
					r_status = ST_EMPTY;
				end else begin
					r_data = cell_data[0];
				end
			end
			OP_PEEK_NEW: begin
				if (empty_now) begin
					r_data   = EMPTY_WORD;
					r_status = ST_EMPTY;
				end else begin
					r_data = newest_q;
				end
			end
			default: begin
				r_data = '0;
			end
		endcase
	end

	assign ctl = {accept && do_enq, accept && do_deq};

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			newest_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q     <= r_data;
			status_q   <= r_status;
			is_empty_q <= r_empty;
			is_full_q  <= r_full;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign is_empty  = is_empty_q;
	assign is_full   = is_full_q;

endmodule

`default_nettype wire

/* rtl/cfq_cell.sv */
// One storage cell of the queue chain: holds a word and an occupied bit.
`default_nettype none

module cfq_cell (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cfq_pkg::cfq_ctl_t                  ctl,
	input  wire logic signed [cfq_pkg::WORD_W-1:0]  value,
	input  wire logic                               prev_valid,
	input  wire logic                               next_valid,
	input  wire logic signed [cfq_pkg::WORD_W-1:0]  next_data,
	output logic                                    valid,
	output logic signed [cfq_pkg::WORD_W-1:0]       data
);
	import cfq_pkg::*;

	logic                     valid_q;
	logic signed [WORD_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.deq) begin
			valid_q <= next_valid;
		end else if (ctl.enq && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.deq) begin
			data_q <= next_data;
		end else if (ctl.enq && !valid_q && prev_valid) begin
			data_q <= value;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

`default_nettype wire

/* rtl/cfq_checker.sv */
// Port-level checks for the circular FIFO queue and their binding.
`default_nettype none

module cfq_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_ready,
	input  wire logic [1:0]                         func,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic signed [cfq_pkg::WORD_W-1:0]  data,
	input  wire logic [1:0]                         status,
	input  wire logic                               is_empty,
	input  wire logic                               is_full
);
	import cfq_pkg::*;

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> data == EMPTY_WORD && is_empty)
		else $error("empty refusal without -1 data or empty flag");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> data == '0 && is_full && !is_empty)
		else $error("full refusal with wrong data or flags");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("queue reported both empty and full");

	a_enq_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == OP_ENQ |=> out_valid && !is_empty && data == '0)
		else $error("enqueue result shows an empty queue or nonzero data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status))
		else $error("stalled result changed");

endmodule

bind circular_fifo_queue cfq_checker u_cfq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data      (data),
	.status    (status),
	.is_empty  (is_empty),
	.is_full   (is_full)
);

`default_nettype wire

/* bench/tb_circular_fifo_queue.sv */
// Self-checking testbench for the circular FIFO queue: directed then random ops with live prediction.
module tb_circular_fifo_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import cfq_pkg::*;

	localparam int DEPTH = 128;
	localparam int NUM_ITEMS = 850;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	localparam int RDY_ALWAYS = 0;
	localparam int RDY_COIN = 1;
	localparam int RDY_SPARSE = 2;
	localparam int RDY_LONG_STALL = 3;

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		op_t                      op;
		logic signed [WORD_W-1:0] word;
	} fifo_op_t;

	typedef struct {
		logic signed [WORD_W-1:0] data;
		status_t                  status;
		logic                     is_empty;
		logic                     is_full;
	} fifo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = OP_ENQ;
	logic signed [WORD_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [WORD_W-1:0] data;
	logic [1:0] status;
	logic is_empty;
	logic is_full;

	fifo_op_t pending_ops[$];
	fifo_result_t expected_results[$];
	int n_errors = 0;

	logic [WORD_W-1:0] slots [DEPTH];
	int head_slot = 0;
	int tail_slot = 0;
	bit queue_empty = 1'b1;

	circular_fifo_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data(data),
		.status(status),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	always #1 clk = ~clk;

	function automatic bit queue_full();
		return !queue_empty && ((tail_slot + 1) % DEPTH) == head_slot;
	endfunction

	function automatic fifo_result_t apply_fifo_op(op_t op, logic [WORD_W-1:0] word);
		fifo_result_t r;
		r.data = '0;
		r.status = ST_OK;
		if (op == OP_ENQ) begin
			if (queue_full()) begin
				r.status = ST_FULL;
			end else begin
				if (queue_empty) begin
					head_slot = 0;
					tail_slot = 0;
					queue_empty = 1'b0;
				end else begin
					tail_slot = (tail_slot + 1) % DEPTH;
				end
				slots[tail_slot] = word;
			end
		end else if (queue_empty) begin
			r.data = EMPTY_WORD;
			r.status = ST_EMPTY;
		end else if (op == OP_DEQ) begin
			r.data = slots[head_slot];
			if (head_slot == tail_slot) begin
				head_slot = 0;
				tail_slot = 0;
				queue_empty = 1'b1;
			end else begin
				head_slot = (head_slot + 1) % DEPTH;
			end
		end else if (op == OP_PEEK_OLD) begin
			r.data = slots[head_slot];
		end else begin
			r.data = slots[tail_slot];
		end
		r.is_empty = queue_empty;
		r.is_full = queue_full();
		return r;
	endfunction

	function automatic void add_op(op_t op, logic signed [WORD_W-1:0] word);
		fifo_op_t item;
		item.op = op;
		item.word = word;
		pending_ops.push_back(item);
	endfunction

	// Sender: bursts of items separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		fifo_op_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= OP_ENQ;
			value <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_fifo_op(op_t'(func), value));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					item = pending_ops.pop_front();
					in_valid <= 1'b1;
					func <= item.op;
					value <= item.word;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks results and stalls on a changing pattern.
	int ready_mode = RDY_ALWAYS;
	int mode_left = 0;
	int ready_tick = 0;

	always @(posedge clk or negedge arst_n) begin
		fifo_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no item pending: data %0d, status %0d", data, status);
					n_errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (data !== exp_r.data) begin
						$error("data: expected %0d, got %0d", exp_r.data, data);
						n_errors++;
					end
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						n_errors++;
					end
					if (is_empty !== exp_r.is_empty) begin
						$error("is_empty: expected %0b, got %0b", exp_r.is_empty, is_empty);
						n_errors++;
					end
					if (is_full !== exp_r.is_full) begin
						$error("is_full: expected %0b, got %0b", exp_r.is_full, is_full);
						n_errors++;
					end
				end
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(RDY_ALWAYS, RDY_LONG_STALL);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			ready_tick++;
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
				RDY_SPARSE: out_ready <= (ready_tick % 4 == 0);
				default: out_ready <= (ready_tick % 16 >= 12);
			endcase
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** circular_fifo_queue: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int len;
		int pick;
		int phase_no;
		op_t op;
		logic signed [WORD_W-1:0] word;

		add_op(OP_DEQ, 32'sd5);
		add_op(OP_PEEK_OLD, 32'sd0);
		add_op(OP_PEEK_NEW, -32'sd1);
		add_op(OP_ENQ, WORD_MAX);
		add_op(OP_PEEK_OLD, 32'sd0);
		add_op(OP_PEEK_NEW, 32'sd0);
		add_op(OP_ENQ, WORD_MIN);
		add_op(OP_PEEK_OLD, 32'sd0);
		add_op(OP_PEEK_NEW, 32'sd0);
		add_op(OP_ENQ, 32'sd0);
		add_op(OP_ENQ, -32'sd1);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_PEEK_NEW, 32'sd0);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_ENQ, 32'sh5A5A_5A5A);
		add_op(OP_PEEK_NEW, 32'sd0);
		add_op(OP_DEQ, 32'sd0);
		add_op(OP_PEEK_OLD, 32'sd0);

		// Phases fill, drain or mix; the first fill and then drain so that full and empty are both reached.
		phase_no = 0;
		while (pending_ops.size() < NUM_ITEMS) begin
			mode = (phase_no < 2) ? phase_no : $urandom_range(MODE_FILL, MODE_MIXED);
			len = (mode == MODE_MIXED) ? $urandom_range(10, 60) : $urandom_range(140, 220);
			phase_no++;
			repeat (len) begin
				pick = $urandom_range(0, 99);
				case (mode)
					MODE_FILL: op = (pick < 94) ? OP_ENQ : op_t'($urandom_range(1, 3));
					MODE_DRAIN: op = (pick < 85) ? OP_DEQ : op_t'($urandom_range(0, 3));
					default: op = op_t'($urandom_range(0, 3));
				endcase
				case ($urandom_range(0, 19))
					0: word = WORD_MIN;
					1: word = WORD_MAX;
					2: word = 32'sd0;
					3: word = -32'sd1;
					default: word = $urandom;
				endcase
				add_op(op, word);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (n_errors == 0)
			$display("** circular_fifo_queue: PASSED **");
		else
			$display("** circular_fifo_queue: FAILED **");
		$finish;
	end

endmodule
